[hw/rtl/spq_pkg.sv]
package spq_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = 5;

   // request codes
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_POP    = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_REJECTED = 2'd2;

   typedef struct packed {
      logic [1:0]                    req_type;
      logic signed [VALUE_WIDTH-1:0] value;
   } spq_req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] head_value;
      logic                          is_empty;
      logic [COUNT_WIDTH-1:0]        entry_count;
      logic [1:0]                    status;
   } spq_rsp_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic                          ins;
      logic                          pop;
      logic                          clr;
      logic signed [VALUE_WIDTH-1:0] x;
   } spq_ctrl_type;

endpackage

[hw/rtl/sorted_priority_queue_unit.sv]
// sorted priority queue of signed values, smallest at the head
// req channel: one transaction per operation (insert, pop smallest, clear all);
//   code 3 is a no-op that reports the current contents
// rsp channel: exactly one transaction per request with the head value after
//   the operation (zero when empty), an empty flag, the entry count and a status
//   (ok, pop on empty, insert rejected because full)
// the row of cells compares the new value against every slot at once and
// shifts in the same cycle
// the response is registered and appears the cycle after the request
// one transaction per cycle while rsp_stall is low
// when the receiver stalls, the pending response holds and req_stall rises
//   until it is taken; no work is lost
// reset (synchronous, active high) empties the queue and drops any pending
//   response; no clearing pass is needed
// QUEUE_DEPTH sets the number of cells; entry_count is 5 bits wide, so
//   depths above 31 report a truncated count
module sorted_priority_queue_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  spq_pkg::spq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output spq_pkg::spq_rsp_type rsp_data
);
   import spq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [CW-1:0]                 cnt_ff;
   logic [CW-1:0]                 cnt_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   spq_rsp_type                   rsp_ff;
   spq_rsp_type                   rsp_in;
   spq_ctrl_type                  ctrl;
   logic                          accept;
   logic                          full;
   logic                          empty;
   logic [1:0]                    status;

   logic signed [VALUE_WIDTH-1:0] cell_value [QUEUE_DEPTH];
   logic signed [VALUE_WIDTH-1:0] cell_next  [QUEUE_DEPTH];
   logic                          cell_valid [QUEUE_DEPTH];
   logic                          cell_gt    [QUEUE_DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (cnt_ff == CW'(QUEUE_DEPTH));
   assign empty     = (cnt_ff == '0);

   always_comb begin
      ctrl     = '0;
      ctrl.x   = req_data.value;
      status   = STATUS_OK;
      cnt_in   = cnt_ff;
      if (accept) begin
         case (req_data.req_type)
            REQ_INSERT: begin
               if (full) begin
                  status = STATUS_REJECTED;
               end else begin
                  ctrl.ins = 1'b1;
                  cnt_in   = cnt_ff + 1'b1;
               end
            end
            REQ_POP: begin
               if (empty) begin
                  status = STATUS_EMPTY;
               end else begin
                  ctrl.pop = 1'b1;
                  cnt_in   = cnt_ff - 1'b1;
               end
            end
            REQ_CLEAR: begin
               ctrl.clr = 1'b1;
               cnt_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         logic signed [VALUE_WIDTH-1:0] lv;
         logic                          lval;
         logic                          lgt;
         logic signed [VALUE_WIDTH-1:0] rv;
         logic                          rval;

         // the head cell sees a valid neighbor that is never greater
         if (gi == 0) begin : g_first
            assign lv   = cell_value[gi];
            assign lval = 1'b1;
            assign lgt  = 1'b0;
         end else begin : g_mid
            assign lv   = cell_value[gi-1];
            assign lval = cell_valid[gi-1];
            assign lgt  = cell_gt[gi-1];
         end

         if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign rv   = cell_value[gi];
            assign rval = 1'b0;
         end else begin : g_inner
            assign rv   = cell_value[gi+1];
            assign rval = cell_valid[gi+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .left_value  (lv),
            .left_valid  (lval),
            .left_gt     (lgt),
            .right_value (rv),
            .right_valid (rval),
            .value       (cell_value[gi]),
            .valid       (cell_valid[gi]),
            .gt          (cell_gt[gi]),
            .next_value  (cell_next[gi])
         );
      end
   endgenerate

   always_comb begin
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in       = 1'b1;
         rsp_in.head_value  = (cnt_in != '0) ? cell_next[0] : '0;
         rsp_in.is_empty    = (cnt_in == '0);
         rsp_in.entry_count = COUNT_WIDTH'(cnt_in);
         rsp_in.status      = status;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hw/rtl/spq_cell.sv]
module spq_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  spq_pkg::spq_ctrl_type                  ctrl,
   input  logic signed [spq_pkg::VALUE_WIDTH-1:0] left_value,
   input  logic                                   left_valid,
   input  logic                                   left_gt,
   input  logic signed [spq_pkg::VALUE_WIDTH-1:0] right_value,
   input  logic                                   right_valid,
   output logic signed [spq_pkg::VALUE_WIDTH-1:0] value,
   output logic                                   valid,
   output logic                                   gt,
   output logic signed [spq_pkg::VALUE_WIDTH-1:0] next_value
);
   import spq_pkg::*;

   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] value_in;
   logic                          valid_ff;
   logic                          valid_in;

   // stored value strictly greater than the new one: the new value goes ahead of it
   assign gt = valid_ff && (value_ff > ctrl.x);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.clr) begin
         valid_in = 1'b0;
      end else if (ctrl.pop) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (ctrl.ins) begin
         valid_in = valid_ff || left_valid;
         if (left_gt) begin
            value_in = left_value;
         end else if (left_valid && (gt || !valid_ff)) begin
            value_in = ctrl.x;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value      = value_ff;
   assign valid      = valid_ff;
   assign next_value = value_in;

endmodule
